/* rtl/sha_pkg.sv */
// Shared types, constants and the rotate function for the SHA-256 stream hasher.
// Used by the controller, the datapath and the top level; no dependencies.
package sha_pkg;

    localparam logic [1:0] CMD_ABSORB        = 2'd0;
    localparam logic [1:0] CMD_ABSORB_FINISH = 2'd1;
    localparam logic [1:0] CMD_FINISH        = 2'd2;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [6:0] LEN_POS  = 7'd56;
    localparam logic [60:0] MAX_BYTES = {61{1'b1}};

    // Byte source selection for the block buffer.
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } byte_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      push;        // write one byte into the block buffer
        byte_src_t src;         // which byte to write
        logic      count;       // count the byte in the message length
        logic      set_ovf;     // mark the length overflow
        logic      comp_start;  // load working variables from chaining value
        logic      round;       // run one compression round
        logic      comp_end;    // fold working variables into chaining value
        logic      restart;     // return to the initial hash value
        logic      out_shift;   // advance the digest output word
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [6:0]  fill;
        logic        len_max;
        logic [5:0]  round_idx;
    } dp_stat_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* rtl/sha_datapath.sv */
// Datapath of the SHA-256 stream hasher: block buffer held in the message
// schedule window, length counter, one-round compression unit and digest
// output shifter. Depends on sha_pkg.
module sha_datapath
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [7:0]  data_byte,
    output dp_stat_t    stat,
    output logic [31:0] digest_word,
    output logic        length_overflow
);

    logic [6:0]  fill_reg;
    logic [60:0] len_reg;
    logic        ovf_reg;
    logic [31:0] cv_reg [8];
    logic [31:0] wv_reg [8];
    logic [31:0] win_reg [16];
    logic [5:0]  round_reg;
    logic [7:0]  byte_in;
    logic [63:0] bits;
    logic [31:0] w_cur, w_new, t1, t2, s0, s1, w15, w2, a, e;

    assign bits = {len_reg, 3'b000};

    // Select the byte written into the buffer.
    always_comb
    begin
        case (cmd.src)
            SRC_DATA: byte_in = data_byte;
            SRC_PAD:  byte_in = PAD_BYTE;
            SRC_ZERO: byte_in = 8'h00;
            SRC_LEN:  byte_in = bits[8 * (7 - (fill_reg[2:0])) +: 8];
            default:  byte_in = 8'h00;
        endcase
    end

    // Schedule word and round arithmetic for the current round.
    always_comb
    begin
        w15 = win_reg[1];
        w2  = win_reg[14];
        s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        w_new = win_reg[0] + s0 + win_reg[9] + s1;
        w_cur = (round_reg < 6'd16) ? win_reg[0] : w_new;
        a = wv_reg[0];
        e = wv_reg[4];
        t1 = wv_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
           + ((e & wv_reg[5]) ^ (~e & wv_reg[6])) + ROUND_K[round_reg] + w_cur;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
           + ((a & wv_reg[1]) ^ (a & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));
    end

    // Control registers: fill level, length, overflow flag, round counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                fill_reg <= '0;
                len_reg  <= '0;
                ovf_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.push)
                    fill_reg <= fill_reg + 7'd1;
                else if (cmd.comp_end)
                    fill_reg <= '0;
                if (cmd.count)
                    len_reg <= len_reg + 61'd1;
                if (cmd.set_ovf)
                    ovf_reg <= 1'b1;
            end
            if (cmd.comp_start)
                round_reg <= '0;
            else if (cmd.round)
                round_reg <= round_reg + 6'd1;
        end
    end

    // The schedule window doubles as the block buffer: each byte lands
    // big-endian in its word, and the rounds rotate or extend it in place.
    always_ff @(posedge clk)
    begin
        if (cmd.comp_start)
        begin
            for (int i = 0; i < 8; i++)
                wv_reg[i] <= cv_reg[i];
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[15] <= w_cur;
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= e;
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= a;
            wv_reg[0] <= t1 + t2;
        end
        else if (cmd.push)
        begin
            win_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= byte_in;
        end
    end

    // Chaining value: fold, restart and output shifting.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                cv_reg[i] <= INIT_HASH[i];
        end
        else if (cmd.restart)
        begin
            for (int i = 0; i < 8; i++)
                cv_reg[i] <= INIT_HASH[i];
        end
        else if (cmd.comp_end)
        begin
            for (int i = 0; i < 8; i++)
                cv_reg[i] <= cv_reg[i] + wv_reg[i];
        end
        else if (cmd.out_shift)
        begin
            for (int i = 0; i < 7; i++)
                cv_reg[i] <= cv_reg[i+1];
            cv_reg[7] <= cv_reg[0];
        end
    end

    assign stat.fill       = fill_reg;
    assign stat.len_max    = (len_reg == MAX_BYTES);
    assign stat.round_idx  = round_reg;
    assign digest_word     = cv_reg[0];
    assign length_overflow = ovf_reg;

endmodule

/* rtl/sha_controller.sv */
// Controller of the SHA-256 stream hasher: input acceptance, padding
// sequence, compression rounds and digest output. Depends on sha_pkg.
module sha_controller
    import sha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic       out_ready,
    output logic       out_valid,
    output logic [2:0] word_index,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_ROUND = 7'b0000100,
        ST_FOLD  = 7'b0001000,
        ST_PAD   = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_PADX  = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic       fin_reg, fin_next;   // finish pending after this compression
    logic [1:0] pad_reg, pad_next;   // 0: 0x80 next, 1: zeros, 2: length
    logic [2:0] idx_reg, idx_next;
    logic       acc, absorb_ok;

    assign in_ready   = (state_reg == ST_IDLE);
    assign acc        = in_valid && in_ready;
    assign out_valid  = (state_reg == ST_OUT);
    assign word_index = idx_reg;
    assign absorb_ok  = !stat.len_max;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        pad_next   = pad_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.src    = SRC_DATA;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc && (command == CMD_ABSORB || command == CMD_ABSORB_FINISH))
                begin
                    fin_next = (command == CMD_ABSORB_FINISH);
                    pad_next = 2'd0;
                    if (absorb_ok)
                    begin
                        cmd.push  = 1'b1;
                        cmd.count = 1'b1;
                        if (stat.fill == 7'd63)
                            state_next = ST_LOAD;
                        else if (fin_next)
                            state_next = ST_PAD;
                    end
                    else
                    begin
                        cmd.set_ovf = 1'b1;
                        if (fin_next)
                            state_next = ST_PAD;
                    end
                end
                else if (acc && command == CMD_FINISH)
                begin
                    fin_next   = 1'b1;
                    pad_next   = 2'd0;
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                cmd.push = 1'b1;
                if (pad_reg == 2'd0)
                begin
                    cmd.src  = SRC_PAD;
                    pad_next = (stat.fill == 7'd55) ? 2'd2 : 2'd1;
                end
                else if (pad_reg == 2'd1)
                begin
                    cmd.src = SRC_ZERO;
                    if (stat.fill == 7'd55)
                        pad_next = 2'd2;
                end
                else
                begin
                    cmd.src = SRC_LEN;
                end
                if (stat.fill == 7'd63)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.comp_start = 1'b1;
                state_next     = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (stat.round_idx == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.comp_end = 1'b1;
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (pad_reg == 2'd2 && stat.fill == 7'd64)
                begin
                    idx_next   = 3'd0;
                    state_next = ST_OUT;
                end
                else
                    state_next = ST_PADX;
            end
            ST_PADX:
            begin
                // Pad continues in a fresh block after the fold cleared the fill.
                state_next = ST_PAD;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    cmd.out_shift = 1'b1;
                    idx_next      = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.out_shift = 1'b0;
                        cmd.restart   = 1'b1;
                        fin_next      = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            pad_reg   <= 2'd0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            pad_reg   <= pad_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* rtl/sha256_stream_hasher.sv */
// Top level of the SHA-256 stream hasher: stream ports, controller and
// datapath. Depends on sha_pkg, sha_controller and sha_datapath.
//
// Bytes stream in one per transfer, and every 64th byte starts a
// compression (load, 64 rounds at one round per cycle in the shared round
// unit, fold), during which no transfer is taken. A finish adds the padding
// at one byte per cycle plus one or two compressions, then the eight digest
// words leave first word first, one per cycle while the sink is ready.
// Command 3 is accepted and ignored.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, 39:35 zero
    output logic        m_tuser,   // [0] length_overflow
    output logic        m_tlast    // last_word
);

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        length_overflow;

    sha_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .command    (s_tuser),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .word_index (word_index),
        .stat       (stat),
        .cmd        (cmd)
    );

    sha_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .data_byte       (s_tdata),
        .stat            (stat),
        .digest_word     (digest_word),
        .length_overflow (length_overflow)
    );

    assign m_tdata = {5'b00000, word_index, digest_word};
    assign m_tuser = length_overflow;
    assign m_tlast = (word_index == 3'd7);

endmodule
